>>> hw/rtl/bfr_pkg.sv
`timescale 1ns / 1ps
package bfr_pkg;

  localparam int TRIG_N = 30;          // rotation CORDIC iterations
  localparam int VEC_N  = 32;          // vectoring CORDIC iterations
  localparam int TW     = 32;          // cos/sin width, Q2.30
  localparam int VW     = 38;          // N/D component width in the vectoring stages
  localparam int MW     = 36;          // magnitude width fed to the divider
  localparam int QW     = MW + 24;     // quotient width, Q24
  localparam int PW     = 64;          // powered magnitude width
  localparam int CW     = 32;          // coefficient / gain width
  localparam int OW     = 4;           // cascade order width
  localparam int NSTEP  = (1 << OW) - 1;

  localparam logic signed [TW-1:0] CORDIC_K30 = 32'sd652032874;

  localparam int LAT = (TRIG_N + 1) + 1 + 1 + (VEC_N + 1) + 1 + QW + 2 * NSTEP + 2;

  typedef enum logic [2:0] {
    CFG_B0,
    CFG_B1,
    CFG_B2,
    CFG_A1,
    CFG_A2,
    CFG_ORDER,
    CFG_GAIN
  } cfg_idx_t;

  // arctan(2^-i) with one turn = 2^32
  function automatic logic [31:0] atan_at(input int i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/bfr_trig.sv
`timescale 1ns / 1ps
module bfr_trig (
  input  logic                           clk,
  input  logic                           en,
  input  logic [31:0]                    ang,
  output logic signed [bfr_pkg::TW-1:0]  cos_o,
  output logic signed [bfr_pkg::TW-1:0]  sin_o
);
  import bfr_pkg::*;

  logic signed [TW-1:0] x_r [0:TRIG_N];
  logic signed [TW-1:0] y_r [0:TRIG_N];
  logic signed [TW:0]   z_r [0:TRIG_N];
  logic [1:0]           q_r [0:TRIG_N];

  // quadrant goes around the CORDIC, residual angle into it
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CORDIC_K30;
      y_r[0] <= '0;
      z_r[0] <= signed'({3'b000, ang[29:0]});
      q_r[0] <= ang[31:30];
    end
  end

  for (genvar i = 0; i < TRIG_N; i++) begin : g_it
    logic signed [TW-1:0] xs;
    logic signed [TW-1:0] ys;
    logic signed [TW:0]   at;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    assign at = signed'((TW+1)'(atan_at(i)));

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][TW]) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + at;
        end
        q_r[i+1] <= q_r[i];
      end
    end
  end

  always_comb begin
    unique case (q_r[TRIG_N])
      2'b00: begin cos_o = x_r[TRIG_N];  sin_o = y_r[TRIG_N];  end
      2'b01: begin cos_o = -y_r[TRIG_N]; sin_o = x_r[TRIG_N];  end
      2'b10: begin cos_o = -x_r[TRIG_N]; sin_o = -y_r[TRIG_N]; end
      default: begin cos_o = y_r[TRIG_N]; sin_o = -x_r[TRIG_N]; end
    endcase
  end

endmodule

>>> hw/rtl/bfr_vec.sv
`timescale 1ns / 1ps
module bfr_vec (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [bfr_pkg::VW-1:0]  x_in,
  input  logic signed [bfr_pkg::VW-1:0]  y_in,
  output logic signed [bfr_pkg::VW-1:0]  mag_o,
  output logic [31:0]                    ang_o
);
  import bfr_pkg::*;

  logic signed [VW-1:0] x_r [0:VEC_N];
  logic signed [VW-1:0] y_r [0:VEC_N];
  logic [31:0]          a_r [0:VEC_N];
  logic                 zf_r [0:VEC_N];

  // fold the left half plane over, starting at pi
  always_ff @(posedge clk) begin
    if (en) begin
      zf_r[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[VW-1]) begin
        x_r[0] <= -x_in;
        y_r[0] <= -y_in;
        a_r[0] <= 32'h8000_0000;
      end else begin
        x_r[0] <= x_in;
        y_r[0] <= y_in;
        a_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < VEC_N; i++) begin : g_it
    logic signed [VW-1:0] xs;
    logic signed [VW-1:0] ys;
    logic                 pos;
    assign xs  = x_r[i] >>> i;
    assign ys  = y_r[i] >>> i;
    assign pos = !y_r[i][VW-1] && (y_r[i] != '0);

    always_ff @(posedge clk) begin
      if (en) begin
        if (pos) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          a_r[i+1] <= a_r[i] + atan_at(i);
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          a_r[i+1] <= a_r[i] - atan_at(i);
        end
        zf_r[i+1] <= zf_r[i];
      end
    end
  end

  assign mag_o = zf_r[VEC_N] ? '0 : x_r[VEC_N];
  assign ang_o = zf_r[VEC_N] ? '0 : a_r[VEC_N];

endmodule

>>> hw/rtl/biquad_frequency_response.sv
`timescale 1ns / 1ps
// Biquad frequency response evaluator.
// Input channel (in_valid/in_ready): one request per normalized frequency
// f = in_norm_frequency / 65536 of the sample rate.
// Result channel (out_valid/out_ready): out_magnitude = gain * |H|^order in
// unsigned Q8.24 (saturating), out_phase = arg(H) as a signed fraction of pi,
// out_saturated set on clipping or when the denominator is zero.
// Config port: cfg_we/cfg_index/cfg_data write b0, b1, b2, a1, a2 (Q4.28),
// cascade order and gain (Q8.24); write only while no request is in flight.
// The pipeline runs through the sin/cos CORDIC, the tap products and sums,
// the vectoring CORDIC, a phase stage, the one bit per stage divider, the
// power (two stages per multiply) and the gain.
// Throughput is one request per cycle while no result waits on out_ready.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// coefficients (pass-through, order 1, unity gain).
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline freezes; in_ready drops until the result is taken.
module biquad_frequency_response (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_norm_frequency,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_magnitude,
  output logic signed [15:0] out_phase,
  output logic        out_saturated,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import bfr_pkg::*;

  logic en;
  logic [LAT-1:0] vld_r;

  logic signed [CW-1:0] num_b0_r, num_b1_r, num_b2_r, den_a1_r, den_a2_r;
  logic [OW-1:0]        order_r;
  logic [CW-1:0]        gain_r;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_b0_r <= 32'sd268435456;
      num_b1_r <= '0;
      num_b2_r <= '0;
      den_a1_r <= '0;
      den_a2_r <= '0;
      order_r  <= 4'd1;
      gain_r   <= 32'd16777216;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_B0:    num_b0_r <= cfg_data;
        CFG_B1:    num_b1_r <= cfg_data;
        CFG_B2:    num_b2_r <= cfg_data;
        CFG_A1:    den_a1_r <= cfg_data;
        CFG_A2:    den_a2_r <= cfg_data;
        CFG_ORDER: order_r  <= cfg_data[OW-1:0];
        CFG_GAIN:  gain_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // sin/cos of theta and 2*theta
  logic signed [TW-1:0] cos1, sin1, cos2, sin2;

  bfr_trig u_trig1 (
    .clk   (clk),
    .en    (en),
    .ang   ({in_norm_frequency, 16'b0}),
    .cos_o (cos1),
    .sin_o (sin1)
  );

  bfr_trig u_trig2 (
    .clk   (clk),
    .en    (en),
    .ang   ({in_norm_frequency[14:0], 17'b0}),
    .cos_o (cos2),
    .sin_o (sin2)
  );

  // tap products
  logic signed [63:0] pn1c_r, pn1s_r, pn2c_r, pn2s_r;
  logic signed [63:0] pd1c_r, pd1s_r, pd2c_r, pd2s_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pn1c_r <= 64'(num_b1_r) * 64'(cos1);
      pn1s_r <= 64'(num_b1_r) * 64'(sin1);
      pn2c_r <= 64'(num_b2_r) * 64'(cos2);
      pn2s_r <= 64'(num_b2_r) * 64'(sin2);
      pd1c_r <= 64'(den_a1_r) * 64'(cos1);
      pd1s_r <= 64'(den_a1_r) * 64'(sin1);
      pd2c_r <= 64'(den_a2_r) * 64'(cos2);
      pd2s_r <= 64'(den_a2_r) * 64'(sin2);
    end
  end

  // N and D sums, each term floored to Q28
  logic signed [63:0] nr_w, ni_w, dr_w, di_w;
  logic signed [VW-1:0] nr_r, ni_r, dr_r, di_r;

  assign nr_w = 64'(num_b0_r) + (pn1c_r >>> 30) + (pn2c_r >>> 30);
  assign ni_w = -(pn1s_r >>> 30) - (pn2s_r >>> 30);
  assign dr_w = 64'sd268435456 + (pd1c_r >>> 30) + (pd2c_r >>> 30);
  assign di_w = -(pd1s_r >>> 30) - (pd2s_r >>> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      nr_r <= nr_w[VW-1:0];
      ni_r <= ni_w[VW-1:0];
      dr_r <= dr_w[VW-1:0];
      di_r <= di_w[VW-1:0];
    end
  end

  logic signed [VW-1:0] mag_n, mag_d;
  logic [31:0]          ang_n, ang_d;

  bfr_vec u_vec_n (
    .clk   (clk),
    .en    (en),
    .x_in  (nr_r),
    .y_in  (ni_r),
    .mag_o (mag_n),
    .ang_o (ang_n)
  );

  bfr_vec u_vec_d (
    .clk   (clk),
    .en    (en),
    .x_in  (dr_r),
    .y_in  (di_r),
    .mag_o (mag_d),
    .ang_o (ang_d)
  );

  // divider: |N| * 2^24 / |D|, one quotient bit per stage
  logic [MW-1:0] dv_rem_r [0:QW];
  logic [QW-1:0] dv_quo_r [0:QW];
  logic [QW-1:0] dv_nd_r  [0:QW];
  logic [MW-1:0] dv_d_r   [0:QW];
  logic          dv_dz_r  [0:QW];
  logic [15:0]   dv_ph_r  [0:QW];
  logic [31:0]   ph_w;

  assign ph_w = ang_n - ang_d + 32'h0000_8000;

  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0] <= '0;
      dv_quo_r[0] <= '0;
      dv_nd_r[0]  <= {mag_n[MW-1:0], 24'b0};
      dv_d_r[0]   <= mag_d[MW-1:0];
      dv_dz_r[0]  <= mag_d[VW-1] || (mag_d == '0);
      dv_ph_r[0]  <= ph_w[31:16];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [MW:0] rs;
    logic [MW:0] df;
    logic        ge;
    assign rs = {dv_rem_r[j], dv_nd_r[j][QW-1]};
    assign df = rs - {1'b0, dv_d_r[j]};
    assign ge = rs >= {1'b0, dv_d_r[j]};

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[j+1] <= ge ? df[MW-1:0] : rs[MW-1:0];
        dv_quo_r[j+1] <= {dv_quo_r[j][QW-2:0], ge};
        dv_nd_r[j+1]  <= {dv_nd_r[j][QW-2:0], 1'b0};
        dv_d_r[j+1]   <= dv_d_r[j];
        dv_dz_r[j+1]  <= dv_dz_r[j];
        dv_ph_r[j+1]  <= dv_ph_r[j];
      end
    end
  end

  // power: one Q24 multiply per step, split into 32x32 partial products
  logic [63:0]   pa_ll_r [0:NSTEP-1];
  logic [63:0]   pa_lh_r [0:NSTEP-1];
  logic [63:0]   pa_hl_r [0:NSTEP-1];
  logic [63:0]   pa_hh_r [0:NSTEP-1];
  logic [PW-1:0] pa_p_r  [0:NSTEP-1];
  logic [QW-1:0] pa_q_r  [0:NSTEP-1];
  logic          pa_sat_r[0:NSTEP-1];
  logic          pa_dz_r [0:NSTEP-1];
  logic [15:0]   pa_ph_r [0:NSTEP-1];
  logic [PW-1:0] pb_p_r  [0:NSTEP-1];
  logic [QW-1:0] pb_q_r  [0:NSTEP-1];
  logic          pb_sat_r[0:NSTEP-1];
  logic          pb_dz_r [0:NSTEP-1];
  logic [15:0]   pb_ph_r [0:NSTEP-1];

  for (genvar k = 0; k < NSTEP; k++) begin : g_pow
    logic [PW-1:0]  p_in;
    logic [QW-1:0]  q_in;
    logic           sat_in;
    logic           dz_in;
    logic [15:0]    ph_in;
    logic [63:0]    r64;
    logic [127:0]   full;
    logic           act;
    logic           ovf;

    if (k == 0) begin : g_first
      assign p_in   = PW'(1) << 24;
      assign q_in   = dv_quo_r[QW];
      assign sat_in = 1'b0;
      assign dz_in  = dv_dz_r[QW];
      assign ph_in  = dv_ph_r[QW];
    end else begin : g_next
      assign p_in   = pb_p_r[k-1];
      assign q_in   = pb_q_r[k-1];
      assign sat_in = pb_sat_r[k-1];
      assign dz_in  = pb_dz_r[k-1];
      assign ph_in  = pb_ph_r[k-1];
    end

    assign r64  = 64'(q_in);
    assign full = {64'b0, pa_ll_r[k]} + {32'b0, pa_lh_r[k], 32'b0}
                + {32'b0, pa_hl_r[k], 32'b0} + {pa_hh_r[k], 64'b0};
    assign act  = (OW'(k) < order_r) && !pa_sat_r[k];
    assign ovf  = |full[127:64];

    always_ff @(posedge clk) begin
      if (en) begin
        pa_ll_r[k]  <= 64'(p_in[31:0]) * 64'(r64[31:0]);
        pa_lh_r[k]  <= 64'(p_in[31:0]) * 64'(r64[63:32]);
        pa_hl_r[k]  <= 64'(p_in[63:32]) * 64'(r64[31:0]);
        pa_hh_r[k]  <= 64'(p_in[63:32]) * 64'(r64[63:32]);
        pa_p_r[k]   <= p_in;
        pa_q_r[k]   <= q_in;
        pa_sat_r[k] <= sat_in;
        pa_dz_r[k]  <= dz_in;
        pa_ph_r[k]  <= ph_in;

        pb_p_r[k]   <= (act && !ovf) ? {24'b0, full[63:24]} : pa_p_r[k];
        pb_sat_r[k] <= pa_sat_r[k] || (act && ovf);
        pb_q_r[k]   <= pa_q_r[k];
        pb_dz_r[k]  <= pa_dz_r[k];
        pb_ph_r[k]  <= pa_ph_r[k];
      end
    end
  end

  // gain
  logic [63:0]   g_lo_r, g_hi_r;
  logic          g_sat_r, g_dz_r;
  logic [15:0]   g_ph_r;
  logic [PW-1:0] p_last;
  logic [95:0]   gprod;
  logic          gsat;

  assign p_last = pb_p_r[NSTEP-1];

  always_ff @(posedge clk) begin
    if (en) begin
      g_lo_r  <= 64'(gain_r) * 64'(p_last[31:0]);
      g_hi_r  <= 64'(gain_r) * 64'(p_last[63:32]);
      g_sat_r <= pb_sat_r[NSTEP-1];
      g_dz_r  <= pb_dz_r[NSTEP-1];
      g_ph_r  <= pb_ph_r[NSTEP-1];
    end
  end

  assign gprod = {32'b0, g_lo_r} + {g_hi_r, 32'b0};
  assign gsat  = g_sat_r || (|gprod[95:56]);

  logic [31:0]        out_mag_r;
  logic signed [15:0] out_ph_r;
  logic               out_sat_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (g_dz_r) begin
        out_mag_r <= (order_r == '0) ? gain_r : '1;
        out_ph_r  <= '0;
        out_sat_r <= 1'b1;
      end else begin
        out_mag_r <= gsat ? '1 : gprod[55:24];
        out_ph_r  <= g_ph_r;
        out_sat_r <= gsat;
      end
    end
  end

  assign out_magnitude = out_mag_r;
  assign out_phase     = out_ph_r;
  assign out_saturated = out_sat_r;

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("valid pipeline moved during a stall");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with no result pending");

  a_den_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[LAT-2] && g_dz_r |=> out_saturated && (out_phase == '0))
    else $error("zero denominator not flagged");

endmodule

>>> test/tb_biquad_frequency_response.sv
`timescale 1ns / 1ps
module tb_biquad_frequency_response;
  import bfr_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic [15:0] freq;
    logic [31:0] mag;
    logic [15:0] phase;
    logic        sat;
  } resp_t;

  class resp_scoreboard;
    logic [31:0] b0, b1, b2, a1, a2, gain;
    logic [3:0]  order;
    resp_t       pending_q[$];
    int          n_req, n_sat;

    function new();
      b0 = 32'd268435456; b1 = 0; b2 = 0; a1 = 0; a2 = 0;
      order = 4'd1; gain = 32'd16777216;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] v);
      case (idx)
        CFG_B0:    b0 = v;
        CFG_B1:    b1 = v;
        CFG_B2:    b2 = v;
        CFG_A1:    a1 = v;
        CFG_A2:    a2 = v;
        CFG_ORDER: order = v[3:0];
        CFG_GAIN:  gain = v;
        default: ;
      endcase
    endfunction

    function longint unsigned atan_step(int i);
      return longint'(atan_at(i));
    endfunction

    // rotation: cos/sin in Q2.30 of an angle with 2^32 per turn
    function void sincos(logic [31:0] ang, output longint c, output longint s);
      longint x, y, z, t;
      x = longint'(CORDIC_K30); y = 0; z = longint'(ang[29:0]);
      for (int i = 0; i < TRIG_N; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_step(i);
        end else begin
          t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_step(i);
        end
      end
      case (ang[31:30])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function void polar(longint xi, longint yi, output longint mag, output logic [31:0] ang);
      longint x, y, t;
      logic [31:0] a;
      x = xi; y = yi; a = 0;
      if (x == 0 && y == 0) begin
        mag = 0; ang = 0; return;
      end
      if (x < 0) begin
        x = -x; y = -y; a = 32'h8000_0000;
      end
      for (int i = 0; i < VEC_N; i++) begin
        if (y > 0) begin
          t = x + (y >>> i); y = y - (x >>> i); x = t; a += atan_at(i);
        end else begin
          t = x - (y >>> i); y = y + (x >>> i); x = t; a -= atan_at(i);
        end
      end
      mag = x; ang = a;
    endfunction

    function void note_request(logic [15:0] f);
      resp_t e;
      longint nr, ni, dr, di, c, s, m_n, m_d, nk, dk;
      logic [31:0] th, ang_n, ang_d, dphi;
      longint unsigned r, p, g, m;
      logic sat;
      e.freq = f; sat = 0;
      th = {f, 16'h0};
      nr = longint'(signed'(b0)); ni = 0;
      dr = 64'sd268435456; di = 0;
      for (int k = 1; k < 3; k++) begin
        sincos(th * k, c, s);
        nk = longint'(signed'(k == 1 ? b1 : b2));
        dk = longint'(signed'(k == 1 ? a1 : a2));
        nr += (nk * c) >>> 30; ni -= (nk * s) >>> 30;
        dr += (dk * c) >>> 30; di -= (dk * s) >>> 30;
      end
      polar(dr, di, m_d, ang_d);
      n_req++;
      if (m_d <= 0) begin
        e.mag = (order == 0) ? gain : 32'hFFFF_FFFF;
        e.phase = 0; e.sat = 1;
      end else begin
        polar(nr, ni, m_n, ang_n);
        r = (longint'(m_n) << 24) / longint'(m_d);
        p = 64'd1 << 24;
        for (int k = 0; k < order; k++) begin
          if (r != 0 && p > 64'hFFFF_FFFF_FFFF_FFFF / r) begin
            sat = 1; break;
          end
          p = (p * r) >> 24;
        end
        g = gain; m = 0;
        if (!sat && g != 0 && p > 64'hFFFF_FFFF_FFFF_FFFF / g) sat = 1;
        if (!sat) begin
          m = (g * p) >> 24;
          if (m > 64'hFFFF_FFFF) sat = 1;
        end
        dphi = ang_n - ang_d + 32'h8000;
        e.mag = sat ? 32'hFFFF_FFFF : m[31:0];
        e.phase = dphi[31:16];
        e.sat = sat;
      end
      if (e.sat) n_sat++;
      pending_q.push_back(e);
    endfunction

    // returns an empty string on a match
    function string check_result(logic [31:0] mag, logic [15:0] ph, logic sat);
      resp_t e;
      if (pending_q.size() == 0)
        return $sformatf("unexpected result mag=%h phase=%h sat=%b", mag, ph, sat);
      e = pending_q.pop_front();
      if (mag !== e.mag || ph !== e.phase || sat !== e.sat)
        return $sformatf("f=%h: got mag=%h phase=%h sat=%b, want mag=%h phase=%h sat=%b",
                         e.freq, mag, ph, sat, e.mag, e.phase, e.sat);
      return "";
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [15:0] in_norm_frequency = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] out_magnitude;
  logic signed [15:0] out_phase;
  logic        out_saturated;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;

  resp_scoreboard resp_sb = new();
  int  n_errors = 0;
  int  n_results = 0;
  int  cycle_cnt = 0;
  bit  steady = 0;   // no idling on either side while set

  biquad_frequency_response i_dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  task automatic report(string msg);
    n_errors++;
    $display("MISMATCH: %s", msg);
  endtask

  always @(posedge clk) begin
    string msg;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Verification failed");
      $finish;
    end
    if (rst_n && in_valid && in_ready) resp_sb.note_request(in_norm_frequency);
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      msg = resp_sb.check_result(out_magnitude, out_phase, out_saturated);
      if (msg != "") report(msg);
    end
  end

  // result side: a random stall after each result is taken
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_ready <= 1;
    forever begin
      do @(posedge clk); while (!(out_valid && out_ready));
      stall = steady ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
        out_ready <= 1;
      end
    end
  end

  task automatic send_freq(logic [15:0] f);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_norm_frequency <= f;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    resp_sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (resp_sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return 0;
      default: return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
    endcase
  endfunction

  task automatic load_coefs(logic [31:0] b0, b1, b2, a1, a2, logic [3:0] ord, logic [31:0] g);
    write_reg(CFG_B0, b0);
    write_reg(CFG_B1, b1);
    write_reg(CFG_B2, b2);
    write_reg(CFG_A1, a1);
    write_reg(CFG_A2, a2);
    write_reg(CFG_ORDER, {28'h0, ord});
    write_reg(CFG_GAIN, g);
    cfg_we <= 0;
  endtask

  initial begin
    logic [15:0] dir_freqs[$] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h4000, 16'hC000,
                                  16'h0001, 16'h5555, 16'hAAAA, 16'h2000, 16'h7FFF,
                                  16'h8001, 16'h1234, 16'hEDCB};
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset defaults: pass-through
    foreach (dir_freqs[i]) send_freq(dir_freqs[i]);
    drain();

    // denominator zero at DC (1 - 2 + 1), with numerator zero and order 0 too
    load_coefs(32'h1000_0000, 0, 0, 32'hE000_0000, 32'h1000_0000, 4'd1, 32'h0100_0000);
    send_freq(16'h0000); send_freq(16'h8000); send_freq(16'h0001);
    drain();
    load_coefs(0, 0, 0, 32'hE000_0000, 32'h1000_0000, 4'd0, 32'hFFFF_FFFF);
    send_freq(16'h0000); send_freq(16'h4000);
    drain();
    load_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 4'd15, 32'hFFFF_FFFF);
    send_freq(16'h0000); send_freq(16'hFFFF); send_freq(16'h3000);
    drain();

    for (int s = 0; s < 10; s++) begin
      case (s)
        0: load_coefs(32'h0400_0000, 32'h0800_0000, 32'h0400_0000,
                      32'hE800_0000, 32'h0A00_0000, 4'd8, 32'h0100_0000);
        1: load_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h8000_0000, 4'd1, 32'h0);
        2: load_coefs(0, 0, 0, 0, 0, 4'd2, 32'h0100_0000);
        default: load_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                            pick_coef(), 4'($urandom_range(0, 9) == 0 ?
                            $urandom_range(9, 15) : $urandom_range(0, 8)),
                            $urandom_range(0, 3) == 0 ? $urandom() :
                            $urandom_range(0, 32'h0400_0000));
      endcase
      steady = (s % 4 == 3);
      repeat (190) send_freq(16'($urandom_range(0, 65535)));
      steady = 0;
      drain();
    end

    foreach (resp_sb.pending_q[i]) report($sformatf("no result for f=%h",
                                                    resp_sb.pending_q[i].freq));
    $display("Swept %0d frequencies over 14 coefficient sets, %0d results checked",
             resp_sb.n_req, n_results);
    $display("%0d responses saturated, including zero-denominator points", resp_sb.n_sat);
    if (n_errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/bfr_pkg.sv
hw/rtl/bfr_trig.sv
hw/rtl/bfr_vec.sv
hw/rtl/biquad_frequency_response.sv
test/tb_biquad_frequency_response.sv
